// ===== rtl/core/adctm_pkg.sv =====
// Package for the trimmed-mean filter with brownout save detector.
// Holds field widths, register indexes, reset values and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package adctm_pkg;

  // Field widths
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 14;
  localparam int TICK_W   = 16;
  localparam int CH_EXT_W = 5;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
  localparam logic [TICK_W-1:0]   TICK_MAX   = 16'hFFFF;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_W-1:0] REG_STARTUP   = 2'd1;
  localparam logic [IDX_W-1:0] REG_HOLD      = 2'd2;
  localparam logic [IDX_W-1:0] REG_POWER_CH  = 2'd3;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd2100;
  localparam logic [TICK_W-1:0]   STARTUP_RST   = 16'd1000;
  localparam logic [TICK_W-1:0]   HOLD_RST      = 16'd5000;
  localparam logic [CH_W-1:0]     POWER_CH_RST  = 3'd0;

  // Output word widths
  localparam int M_TDATA_W = 24;
  localparam int S_TDATA_W = 16;

  // One result word
  typedef struct packed {
    logic                save_latched;
    logic                save_request;
    logic [SAMPLE_W-1:0] filtered_value;
    logic                filtered_valid;
    logic [CH_W-1:0]     out_channel;
  } result_t;

endpackage

// ===== rtl/core/adc_trim_mean_brownout_save.sv =====
// Each result word is registered at the output, or parked in the skid register during a stall.
// Throughput: one word per cycle while the skid is empty; the per-channel window update,
// the trim and the brownout step are one pass of logic from the input port into the state
// and the output register. An output register plus a skid register keep the input side
// open while a result waits. Reset: synchronous, active high; restarts windows, clears
// results, counters and latch, and loads the register defaults.
`timescale 1ns / 1ps

module adc_trim_mean_brownout_save
  import adctm_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // Slave stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [2:0] channel, [14:3] sample, [15] zero
  input  logic                 s_tlast,   // tick_end
  // Master stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] out_channel, [14:3] filtered_value,
                                          // [15] save_request, [16] save_latched, rest zero
  output logic                 m_tuser,   // filtered_valid
  // Configuration
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_EXT_W-1:0] NUM_CH_L = CH_EXT_W'(NUM_CHANNELS);

  // Configuration registers
  logic [SAMPLE_W-1:0] threshold;
  logic [TICK_W-1:0]   startup_delay;
  logic [TICK_W-1:0]   hold_ticks;
  logic [CH_W-1:0]     power_channel;

  // Per-channel window state
  logic [SUM_W-1:0]    win_sum   [NUM_CHANNELS];
  logic [SAMPLE_W-1:0] win_max   [NUM_CHANNELS];
  logic [SAMPLE_W-1:0] win_min   [NUM_CHANNELS];
  logic [1:0]          win_count [NUM_CHANNELS];
  logic [SAMPLE_W-1:0] ch_result [NUM_CHANNELS];

  // Brownout state
  logic [TICK_W-1:0]   startup_cnt;
  logic [TICK_W-1:0]   hold_cnt;
  logic                save_flag;

  // Output register and skid
  result_t             out_q;
  logic                out_valid;
  result_t             skid_q;
  logic                skid_valid;

  // Input fields
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;
  logic                accept;
  logic [CH_EXT_W-1:0] ch_ext;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                ch_in_range;
  logic [CH_EXT_W-1:0] pc_ext;
  logic [CH_IDX_W-1:0] pc_idx;
  logic                pc_in_range;

  // Window update
  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] max_next;
  logic [SAMPLE_W-1:0] min_next;
  logic [1:0]          count_next;
  logic                window_done;
  logic [SAMPLE_W:0]   trim;
  logic [SUM_W-1:0]    diff;
  logic [SUM_W-2:0]    half;
  logic [SAMPLE_W-1:0] result_value;

  // Brownout step
  logic [SAMPLE_W-1:0] power_value;
  logic [TICK_W-1:0]   startup_inc;
  logic [TICK_W-1:0]   startup_next;
  logic [TICK_W-1:0]   hold_next;
  logic                flag_set;
  logic                flag_next;
  logic                pulse;
  logic                low;
  logic                flag_mid;
  result_t             res;

  assign channel = s_tdata[CH_W-1:0];
  assign sample  = s_tdata[CH_W+SAMPLE_W-1:CH_W];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  assign ch_ext      = {2'b00, channel};
  assign ch_idx      = ch_ext[CH_IDX_W-1:0];
  assign ch_in_range = ch_ext < NUM_CH_L;
  assign pc_ext      = {2'b00, power_channel};
  assign pc_idx      = pc_ext[CH_IDX_W-1:0];
  assign pc_in_range = pc_ext < NUM_CH_L;

  // Accumulate the sample and trim max and min when the window fills
  always_comb begin
    sum_next    = win_sum[ch_idx] + {2'b00, sample};
    max_next    = (sample > win_max[ch_idx]) ? sample : win_max[ch_idx];
    min_next    = (sample < win_min[ch_idx]) ? sample : win_min[ch_idx];
    count_next  = win_count[ch_idx] + 2'd1;
    window_done = ch_in_range && (count_next == 2'd0);
    trim        = {1'b0, max_next} + {1'b0, min_next};
    diff        = sum_next - {1'b0, trim};
    half        = (sum_next >= {1'b0, trim}) ? diff[SUM_W-1:1] : '0;
    result_value = (half > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX : half[SAMPLE_W-1:0];
  end

  // Brownout step; forward this word's result when it updates the power channel
  always_comb begin
    power_value  = (window_done && (channel == power_channel)) ? result_value
                                                               : ch_result[pc_idx];
    startup_inc  = (startup_cnt != TICK_MAX) ? startup_cnt + 16'd1 : startup_cnt;
    low          = pc_in_range && (power_value <= threshold);
    flag_set     = 1'b0;
    flag_mid     = save_flag;
    flag_next    = save_flag;
    hold_next    = hold_cnt;
    startup_next = startup_cnt;
    if (s_tlast) begin
      if (startup_inc < startup_delay) begin
        startup_next = startup_inc;
      end else begin
        startup_next = startup_delay;
        flag_set     = low && !save_flag;
        flag_mid     = save_flag || flag_set;
        if (flag_mid) begin
          hold_next = (hold_cnt != TICK_MAX) ? hold_cnt + 16'd1 : hold_cnt;
        end else begin
          hold_next = '0;
        end
        flag_next = (hold_next >= hold_ticks) ? 1'b0 : flag_mid;
      end
    end
    pulse = flag_set;
  end

  // Assemble the result word
  always_comb begin
    res.out_channel    = channel;
    res.filtered_valid = window_done;
    res.filtered_value = window_done ? result_value : '0;
    res.save_request   = pulse;
    res.save_latched   = flag_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RST;
      startup_delay <= STARTUP_RST;
      hold_ticks    <= HOLD_RST;
      power_channel <= POWER_CH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold     <= cfg_data[SAMPLE_W-1:0];
        REG_STARTUP:   startup_delay <= cfg_data[TICK_W-1:0];
        REG_HOLD:      hold_ticks    <= cfg_data[TICK_W-1:0];
        REG_POWER_CH:  power_channel <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Update window state on each accepted word with an in-range channel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        win_sum[i]   <= '0;
        win_max[i]   <= '0;
        win_min[i]   <= SAMPLE_MAX;
        win_count[i] <= '0;
        ch_result[i] <= '0;
      end
    end else if (accept && ch_in_range) begin
      win_count[ch_idx] <= count_next;
      if (window_done) begin
        win_sum[ch_idx]   <= '0;
        win_max[ch_idx]   <= '0;
        win_min[ch_idx]   <= SAMPLE_MAX;
        ch_result[ch_idx] <= result_value;
      end else begin
        win_sum[ch_idx] <= sum_next;
        win_max[ch_idx] <= max_next;
        win_min[ch_idx] <= min_next;
      end
    end
  end

  // Advance brownout state
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_cnt <= '0;
      hold_cnt    <= '0;
      save_flag   <= 1'b0;
    end else if (accept) begin
      startup_cnt <= startup_next;
      hold_cnt    <= hold_next;
      save_flag   <= flag_next;
    end
  end

  // Output register with skid: park the word when the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_q.filtered_valid;
  assign m_tdata  = {7'b0, out_q.save_latched, out_q.save_request,
                     out_q.filtered_value, out_q.out_channel};

endmodule

// ===== rtl/core/adctm_checker.sv =====
// Port-level checker for the trimmed-mean brownout block, bound to the top level.
// Depends on adctm_pkg for widths.
`timescale 1ns / 1ps

module adctm_checker
  import adctm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tuser
);

  // Hold a stalled output word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  // Input side closes only when a word already waits at the output
  a_ready_needs_out: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // A full skid stays full while the output is stalled
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready && m_tvalid && !m_tready |=> !s_tready)
    else $error("skid drained without output transfer");

  // Filtered value reads zero unless a window completed
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[14:3] == 12'd0)
    else $error("filtered value without window end");

endmodule

bind adc_trim_mean_brownout_save adctm_checker u_adctm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== dv/tb_adc_trim_mean_brownout_save.sv =====
// Self-checking bench for the trimmed-mean filter with brownout save detector.
// A directed table, then random phases, are checked word by word against a local predictor or hand-written results.
// Depends on adctm_pkg and adc_trim_mean_brownout_save.
`timescale 1ns / 1ps

module tb_adc_trim_mean_brownout_save;
  import adctm_pkg::*;

  localparam int NUM_CH     = 8;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 105;
  localparam int MAX_REPORT = 10;

  // One row of the directed plan: a register write or a sample word
  typedef struct packed {
    logic                is_reg;
    logic [IDX_W-1:0]    idx;
    logic [CFG_W-1:0]    value;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] smp;
    logic                tick;
    logic                typed;
    result_t             want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_we;
  logic [IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predictor state: per-channel windows and results, brownout counters, registers
  logic [SUM_W-1:0]    win_sum  [NUM_CH];
  logic [SAMPLE_W-1:0] win_max  [NUM_CH];
  logic [SAMPLE_W-1:0] win_min  [NUM_CH];
  logic [1:0]          win_cnt  [NUM_CH];
  logic [SAMPLE_W-1:0] ch_level [NUM_CH];
  logic [TICK_W-1:0]   startup_cnt;
  logic                save_flag;
  logic [TICK_W-1:0]   hold_cnt;
  logic [SAMPLE_W-1:0] threshold_reg;
  logic [TICK_W-1:0]   startup_reg;
  logic [TICK_W-1:0]   hold_reg;
  logic [CH_W-1:0]     power_reg;

  result_t     pending_words [$];
  plan_row_t   plan [$];
  int unsigned gap_odds = 0;
  int          faults   = 0;
  int          words_seen = 0;

  adc_trim_mean_brownout_save #(
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bring the predictor to its reset state
  function automatic void reset_model();
    for (int i = 0; i < NUM_CH; i++) begin
      win_sum[i]  = '0;
      win_max[i]  = '0;
      win_min[i]  = SAMPLE_MAX;
      win_cnt[i]  = '0;
      ch_level[i] = '0;
    end
    startup_cnt   = '0;
    save_flag     = 1'b0;
    hold_cnt      = '0;
    threshold_reg = THRESHOLD_RST;
    startup_reg   = STARTUP_RST;
    hold_reg      = HOLD_RST;
    power_reg     = POWER_CH_RST;
  endfunction

  // Run one brownout step; return 1 when it sets the save latch
  function automatic logic brownout_tick();
    logic pulse;
    logic low;
    pulse = 1'b0;
    if (startup_cnt != TICK_MAX) startup_cnt = startup_cnt + 16'd1;
    if (startup_cnt < startup_reg) return 1'b0;
    // hold the counter at the delay once reached, even if the delay is lowered later
    startup_cnt = startup_reg;
    // with eight channels the power channel index is always in range
    low = (ch_level[power_reg] <= threshold_reg);
    if (low && !save_flag) begin
      save_flag = 1'b1;
      pulse     = 1'b1;
    end
    if (save_flag) begin
      if (hold_cnt != TICK_MAX) hold_cnt = hold_cnt + 16'd1;
    end else begin
      hold_cnt = '0;
    end
    // hold_cnt is not cleared here, so a relatch on a still-low supply clears again in the same step
    if (hold_cnt >= hold_reg) save_flag = 1'b0;
    return pulse;
  endfunction

  // Accumulate one sample and work out the result word it causes
  function automatic result_t filter_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp,
                                            logic tick);
    result_t w;
    int      trim;
    int      level;
    w             = '0;
    w.out_channel = ch;
    win_sum[ch] = win_sum[ch] + SUM_W'(smp);
    if (smp > win_max[ch]) win_max[ch] = smp;
    if (smp < win_min[ch]) win_min[ch] = smp;
    win_cnt[ch] = win_cnt[ch] + 2'd1;
    if (win_cnt[ch] == 2'd0) begin
      trim  = int'(win_max[ch]) + int'(win_min[ch]);
      level = (int'(win_sum[ch]) >= trim) ? ((int'(win_sum[ch]) - trim) >> 1) : 0;
      if (level > int'(SAMPLE_MAX)) level = int'(SAMPLE_MAX);
      ch_level[ch]     = SAMPLE_W'(level);
      win_sum[ch]      = '0;
      win_max[ch]      = '0;
      win_min[ch]      = SAMPLE_MAX;
      w.filtered_valid = 1'b1;
      w.filtered_value = SAMPLE_W'(level);
    end
    if (tick) w.save_request = brownout_tick();
    w.save_latched = save_flag;
    return w;
  endfunction

  function automatic void add_word(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp, logic tick);
    plan_row_t r;
    r      = '0;
    r.ch   = ch;
    r.smp  = smp;
    r.tick = tick;
    plan.push_back(r);
  endfunction

  // Sample word whose result is written out by hand
  function automatic void add_checked(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp,
                                      logic tick, logic valid, logic [SAMPLE_W-1:0] level,
                                      logic req, logic latched);
    plan_row_t r;
    r                     = '0;
    r.ch                  = ch;
    r.smp                 = smp;
    r.tick                = tick;
    r.typed               = 1'b1;
    r.want.out_channel    = ch;
    r.want.filtered_valid = valid;
    r.want.filtered_value = level;
    r.want.save_request   = req;
    r.want.save_latched   = latched;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    plan_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.value  = value;
    plan.push_back(r);
  endfunction

  // Random sample: extremes now and then, the power channel near the threshold
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [CH_W-1:0] ch);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = int'(SAMPLE_MAX);
      default: begin
        if (ch == power_reg)
          v = int'(threshold_reg) + int'($urandom_range(0, 800)) - 400;
        else
          v = int'($urandom_range(0, 4095));
      end
    endcase
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
    return SAMPLE_W'(v);
  endfunction

  task automatic log_fault(string msg);
    faults++;
    if (faults <= MAX_REPORT) $display("%s", msg);
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD: threshold_reg = value[SAMPLE_W-1:0];
      REG_STARTUP:   startup_reg   = value;
      REG_HOLD:      hold_reg      = value;
      REG_POWER_CH:  power_reg     = value[CH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Offer one sample word, predict at acceptance, return on the next falling edge
  task automatic send_word(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp, logic tick,
                           logic typed, result_t want);
    result_t w;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, smp, ch};
    s_tlast  <= tick;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    w = filter_sample(ch, smp, tick);
    pending_words.push_back(typed ? want : w);
    @(negedge clk);
  endtask

  // Receiver: stall in short bursts while idling is on
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.out_channel    = m_tdata[2:0];
      got.filtered_value = m_tdata[14:3];
      got.save_request   = m_tdata[15];
      got.save_latched   = m_tdata[16];
      got.filtered_valid = m_tuser;
      if (pending_words.size() == 0) begin
        log_fault($sformatf("word %0d: result with nothing expected (tdata %h tuser %b)",
                            words_seen, m_tdata, m_tuser));
      end else begin
        want = pending_words.pop_front();
        if (got !== want)
          log_fault($sformatf({"word %0d exp/got: ch %0d/%0d valid %b/%b value %0d/%0d ",
                               "req %b/%b latched %b/%b"}, words_seen,
                              want.out_channel, got.out_channel,
                              want.filtered_valid, got.filtered_valid,
                              want.filtered_value, got.filtered_value,
                              want.save_request, got.save_request,
                              want.save_latched, got.save_latched));
      end
      words_seen++;
    end
  end

  initial begin
    #2_000_000;
    $display("tb_adc_trim_mean_brownout_save: errors");
    $finish;
  end

  // Main sequence: reset, directed plan, random phases, drain
  initial begin
    plan_row_t       row;
    logic [CH_W-1:0] rr_ch;
    logic [CH_W-1:0] ch;
    int              pos;
    int              len;
    int              spins;
    rr_ch = '0;
    pos   = 0;
    len   = 1;
    reset_model();

    // Reset values and window extremes
    add_checked(3'd0, 12'd4095, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0);
    add_checked(3'd0, 12'd0,    1'b1, 1'b0, 12'd0, 1'b0, 1'b0);
    add_word(3'd0, 12'd4095, 1'b0);
    add_word(3'd0, 12'd0,    1'b0);
    repeat (3) add_word(3'd1, 12'd4095, 1'b0);
    add_checked(3'd1, 12'd4095, 1'b0, 1'b1, 12'd4095, 1'b0, 1'b0);
    repeat (3) add_word(3'd2, 12'd0, 1'b0);
    add_checked(3'd2, 12'd0, 1'b0, 1'b1, 12'd0, 1'b0, 1'b0);
    add_word(3'd7, 12'hA5A, 1'b0);
    add_word(3'd7, 12'h5A5, 1'b0);
    add_word(3'd7, 12'h001, 1'b0);
    add_word(3'd7, 12'h800, 1'b0);
    // Short delay and hold: latch, clear by hold, relatch and clear in one step
    add_reg(REG_HOLD, 16'd2);
    add_reg(REG_STARTUP, 16'd2);
    add_reg(REG_POWER_CH, 16'd1);
    add_reg(REG_THRESHOLD, 16'd4095);
    add_word(3'd3, 12'd5, 1'b1);
    add_word(3'd3, 12'd5, 1'b1);
    add_word(3'd3, 12'd5, 1'b1);
    // Threshold zero: supply high, then a zero-level channel as supply
    add_reg(REG_THRESHOLD, 16'd0);
    add_word(3'd4, 12'd0, 1'b1);
    add_reg(REG_POWER_CH, 16'd2);
    add_word(3'd4, 12'd0, 1'b1);
    add_word(3'd3, 12'd5, 1'b1);

    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_odds = 3;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_reg) begin
        settle();
        write_reg(row.idx, row.value);
      end else begin
        send_word(row.ch, row.smp, row.tick, row.typed, row.want);
      end
    end

    // Random phases, each with its own register setting and idling rate
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_THRESHOLD, 16'd4095);
          write_reg(REG_STARTUP, 16'd65535);
          write_reg(REG_HOLD, 16'd1);
          write_reg(REG_POWER_CH, 16'd7);
        end
        1: begin
          write_reg(REG_THRESHOLD, 16'd0);
          write_reg(REG_STARTUP, 16'd1);
          write_reg(REG_HOLD, 16'd65535);
          write_reg(REG_POWER_CH, 16'd0);
        end
        default: begin
          write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 4095)));
          write_reg(REG_STARTUP, CFG_W'($urandom_range(1, 40)));
          write_reg(REG_HOLD, CFG_W'($urandom_range(1, 10)));
          write_reg(REG_POWER_CH, CFG_W'($urandom_range(0, 7)));
        end
      endcase
      // no idling in a middle stretch and in the last phase
      gap_odds = (ph == 4 || ph == PHASES - 1) ? 0 : ((ph % 2 == 0) ? 3 : 6);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise: any channel, any tick marking
          ch = CH_W'($urandom_range(0, 7));
          send_word(ch, pick_sample(ch), 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          // well-formed tick: consecutive channels, tick end on the last one
          if (pos == 0) len = $urandom_range(1, 8);
          ch    = rr_ch;
          rr_ch = rr_ch + 3'd1;
          pos++;
          send_word(ch, pick_sample(ch), pos == len, 1'b0, '0);
          if (pos == len) pos = 0;
        end
      end
    end

    // Drain the expected words, then check that none are left
    s_tvalid <= 1'b0;
    spins = 0;
    while (pending_words.size() != 0 && spins < 1000) begin
      @(posedge clk);
      spins++;
    end
    repeat (4) @(posedge clk);
    if (pending_words.size() != 0)
      log_fault($sformatf("%0d expected words never arrived", pending_words.size()));
    if (faults == 0) begin
      $display("tb_adc_trim_mean_brownout_save: clean");
    end else begin
      $display("tb_adc_trim_mean_brownout_save: errors");
    end
    $finish;
  end

endmodule
